### hw/rtl/dcf_pkg.sv
// Shared types, constants and coefficient table for the DC blocker and FIR bandpass block.
package dcf_pkg;

   // Field widths
   localparam int ADC_W    = 10;
   localparam int SAMPLE_W = 16;
   localparam int DAC_W    = 8;
   localparam int OPND_W   = 17;
   localparam int ACC_W    = 32;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Filter length
   localparam int FIR_ORDER_DEF = 40;
   localparam int COEF_COUNT    = 41;
   localparam int COEF_IDX_W    = $clog2(COEF_COUNT);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DC_NUM_CURRENT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_NUM_PREVIOUS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_FEEDBACK     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAC_OFFSET      = 2'd3;

   // Register reset values
   localparam logic signed [SAMPLE_W-1:0] DC_NUM_CURRENT_RST  = 16'sd32767;
   localparam logic signed [SAMPLE_W-1:0] DC_NUM_PREVIOUS_RST = -16'sd32768;
   localparam logic signed [SAMPLE_W-1:0] DC_FEEDBACK_RST     = 16'sd32309;
   localparam logic [DAC_W-1:0]           DAC_OFFSET_RST      = 8'h7f;

   // Symmetric bandpass coefficients, centre tap 29604
   localparam logic signed [SAMPLE_W-1:0] BAND_COEF [COEF_COUNT] = '{
      -16'sd32,   -16'sd105,  -16'sd238,  -16'sd415,  -16'sd592,  -16'sd704,
      -16'sd681,  -16'sd468,  -16'sd49,   16'sd540,   16'sd1204,  16'sd1806,
      16'sd2193,  16'sd2237,  16'sd1869,  16'sd1102,  16'sd46,    -16'sd1118,
      -16'sd2171, -16'sd2902, 16'sd29604, -16'sd2902, -16'sd2171, -16'sd1118,
      16'sd46,    16'sd1102,  16'sd1869,  16'sd2237,  16'sd2193,  16'sd1806,
      16'sd1204,  16'sd540,   -16'sd49,   -16'sd468,  -16'sd681,  -16'sd704,
      -16'sd592,  -16'sd415,  -16'sd238,  -16'sd105,  -16'sd32
   };

   // Coefficient for tap k; taps past the table weigh zero
   function automatic logic signed [SAMPLE_W-1:0] coef_at(input int unsigned k);
      logic signed [SAMPLE_W-1:0] c;
      c = '0;
      if (k < COEF_COUNT) begin
         c = BAND_COEF[k[COEF_IDX_W-1:0]];
      end
      return c;
   endfunction

   // Control of one tap cell
   typedef struct packed {
      logic en;
      logic rotate;
   } tap_ctrl_type;

   // Control of one multiply-accumulate issue
   typedef struct packed {
      logic valid;
      logic clear;
   } mac_op_type;

endpackage

### hw/rtl/dcf_tap_cell.sv
// One cell of the tap chain: holds one blocker output and moves it to a neighbor.
module dcf_tap_cell
   import dcf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  tap_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] from_prev,
   input  logic signed [SAMPLE_W-1:0] from_next,
   output logic signed [SAMPLE_W-1:0] value
);

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;

   // Shift in from the newer side, or rotate in from the older side
   always_comb begin
      value_in = value_ff;
      if (ctrl.en) begin
         value_in = ctrl.rotate ? from_next : from_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

### hw/rtl/dcf_mac.sv
// Shared multiply-accumulate unit: registered product, then a wrapping 32-bit sum.
module dcf_mac
   import dcf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_op_type               op,
   input  logic signed [OPND_W-1:0] opnd_a,
   input  logic signed [OPND_W-1:0] opnd_b,
   output logic [ACC_W-1:0]         acc
);

   logic signed [2*OPND_W-1:0] prod_ff;
   logic signed [2*OPND_W-1:0] prod_in;
   mac_op_type                 stage_ff;
   logic [ACC_W-1:0]           acc_ff;
   logic [ACC_W-1:0]           acc_in;

   // Multiply stage
   assign prod_in = opnd_a * opnd_b;

   // Accumulate stage, wrapping modulo 2^32
   always_comb begin
      acc_in = acc_ff;
      if (stage_ff.valid) begin
         acc_in = (stage_ff.clear ? '0 : acc_ff) + prod_ff[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= op;
      end
   end

   assign acc = acc_ff;

endmodule

### hw/rtl/dc_block_then_fir_bandpass.sv
// Top level: DC blocker followed by a bandpass FIR over a rotating chain of tap cells.
//
//   channel  direction  ports                   payload
//   req      in         req_tvalid/tready/tdata [9:0] adc_sample
//   rsp      out        rsp_tvalid/tready/tdata [15:0] dc_removed, [31:16] band_output,
//                                               [39:32] dac_code
//   csr      in         csr_wr_en/addr/wdata    register index, 16-bit value
//
// Each accepted item runs in order through the single shared MAC: three blocker terms, a
// drain, one shift, then one tap per cycle over the whole tap chain, another drain and one
// load. No new item is taken until the finished result is loaded into the output register.
// Synchronous active-high reset clears the tap cells and the previous sample and loads the register defaults.
// A result waits in the output register while the next item is taken and processed; the
// finished item holds in its last state only if that register is still full.
module dc_block_then_fir_bandpass
   import dcf_pkg::*;
#(
   parameter int FIR_ORDER = FIR_ORDER_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [9:0] adc_sample
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // [15:0] dc_removed, [31:16] band_output,
                                             // [39:32] dac_code
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int TAP_COUNT = FIR_ORDER + 1;
   localparam int CNT_W     = $clog2(TAP_COUNT + 1);
   localparam logic [CNT_W-1:0] DC_LAST   = CNT_W'(2);
   localparam logic [CNT_W-1:0] WAIT_LAST = CNT_W'(1);
   localparam logic [CNT_W-1:0] FIR_LAST  = CNT_W'(TAP_COUNT - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DC      = 3'd1;
   localparam logic [2:0] S_DCWAIT  = 3'd2;
   localparam logic [2:0] S_SHIFT   = 3'd3;
   localparam logic [2:0] S_FIR     = 3'd4;
   localparam logic [2:0] S_FIRWAIT = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   logic [2:0]                 state_ff, state_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [ADC_W-1:0]           x_ff, x_in;
   logic [ADC_W-1:0]           last_ff, last_in;
   logic signed [SAMPLE_W-1:0] num_cur_ff, num_cur_in;
   logic signed [SAMPLE_W-1:0] num_prev_ff, num_prev_in;
   logic signed [SAMPLE_W-1:0] feedback_ff, feedback_in;
   logic [DAC_W-1:0]           offset_ff, offset_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        dcr_ff, dcr_in;
   logic [SAMPLE_W-1:0]        band_ff, band_in;
   logic [DAC_W-1:0]           dac_ff, dac_in;

   logic                       req_accept;
   logic                       out_load;
   tap_ctrl_type               tap_ctrl;
   mac_op_type                 mac_op;
   logic signed [OPND_W-1:0]   mac_a, mac_b;
   logic [ACC_W-1:0]           mac_acc;
   logic signed [SAMPLE_W-1:0] y_new;
   logic signed [SAMPLE_W-1:0] tap_q [TAP_COUNT];
   logic signed [SAMPLE_W-1:0] coef_cur;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   assign y_new      = mac_acc[ACC_W-1:ACC_W-SAMPLE_W];
   assign coef_cur   = coef_at(int'(cnt_ff));

   // Configuration writes
   always_comb begin
      num_cur_in  = num_cur_ff;
      num_prev_in = num_prev_ff;
      feedback_in = feedback_ff;
      offset_in   = offset_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            CSR_DC_NUM_CURRENT:  num_cur_in  = csr_wdata;
            CSR_DC_NUM_PREVIOUS: num_prev_in = csr_wdata;
            CSR_DC_FEEDBACK:     feedback_in = csr_wdata;
            CSR_DAC_OFFSET:      offset_in   = csr_wdata[DAC_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: blocker terms, drain, shift, FIR taps, drain, deliver
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      x_in     = x_ff;
      last_in  = last_ff;
      tap_ctrl = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               x_in     = req_tdata[ADC_W-1:0];
               cnt_in   = '0;
               state_in = S_DC;
            end
         end
         S_DC: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DC_LAST) begin
               cnt_in   = '0;
               state_in = S_DCWAIT;
            end
         end
         S_DCWAIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WAIT_LAST) begin
               cnt_in   = '0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            tap_ctrl.en = 1'b1;
            last_in     = x_ff;
            cnt_in      = '0;
            state_in    = S_FIR;
         end
         S_FIR: begin
            tap_ctrl.en     = 1'b1;
            tap_ctrl.rotate = 1'b1;
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == FIR_LAST) begin
               cnt_in   = '0;
               state_in = S_FIRWAIT;
            end
         end
         S_FIRWAIT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == WAIT_LAST) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Feed the shared MAC
   always_comb begin
      mac_op = '0;
      mac_a  = {tap_q[0][SAMPLE_W-1], tap_q[0]};
      mac_b  = {coef_cur[SAMPLE_W-1], coef_cur};
      case (state_ff)
         S_DC: begin
            mac_op.valid = 1'b1;
            mac_op.clear = (cnt_ff == '0);
            case (cnt_ff)
               CNT_W'(0): begin
                  mac_a = {{(OPND_W-ADC_W){1'b0}}, x_ff};
                  mac_b = {num_cur_ff[SAMPLE_W-1], num_cur_ff};
               end
               CNT_W'(1): begin
                  mac_a = {{(OPND_W-ADC_W){1'b0}}, last_ff};
                  mac_b = {num_prev_ff[SAMPLE_W-1], num_prev_ff};
               end
               default: begin
                  mac_b = {feedback_ff[SAMPLE_W-1], feedback_ff};
               end
            endcase
         end
         S_FIR: begin
            mac_op.valid = 1'b1;
            mac_op.clear = (cnt_ff == '0);
         end
         default: ;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      dcr_in       = dcr_ff;
      band_in      = band_ff;
      dac_in       = dac_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         dcr_in       = tap_q[0];
         band_in      = mac_acc[ACC_W-1:ACC_W-SAMPLE_W];
         dac_in       = mac_acc[ACC_W-SAMPLE_W+DAC_W:ACC_W-SAMPLE_W+1] + offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      dcr_ff  <= dcr_in;
      band_ff <= band_in;
      dac_ff  <= dac_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         last_ff      <= '0;
         num_cur_ff   <= DC_NUM_CURRENT_RST;
         num_prev_ff  <= DC_NUM_PREVIOUS_RST;
         feedback_ff  <= DC_FEEDBACK_RST;
         offset_ff    <= DAC_OFFSET_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         last_ff      <= last_in;
         num_cur_ff   <= num_cur_in;
         num_prev_ff  <= num_prev_in;
         feedback_ff  <= feedback_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Chain of tap cells, newest in cell 0
   for (genvar i = 0; i < TAP_COUNT; i++) begin : g_tap
      logic signed [SAMPLE_W-1:0] prev_val;
      logic signed [SAMPLE_W-1:0] next_val;
      if (i == 0) begin : g_head
         assign prev_val = y_new;
      end else begin : g_body
         assign prev_val = tap_q[i-1];
      end
      if (i == TAP_COUNT - 1) begin : g_tail
         assign next_val = tap_q[0];
      end else begin : g_inner
         assign next_val = tap_q[i+1];
      end
      dcf_tap_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (tap_ctrl),
         .from_prev (prev_val),
         .from_next (next_val),
         .value     (tap_q[i])
      );
   end

   dcf_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .op     (mac_op),
      .opnd_a (mac_a),
      .opnd_b (mac_b),
      .acc    (mac_acc)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {dac_ff, band_ff, dcr_ff};

   // An accepted item starts the blocker terms on the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_DC)
      else $error("accepted item did not start the blocker phase");

   // The tap chain moves only while shifting or rotating
   a_taps_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_SHIFT && state_ff != S_FIR) |=> $stable(tap_q[0]))
      else $error("tap chain moved outside shift or FIR phase");

   // A loaded result is presented on the next cycle
   a_load_presents: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_tvalid && state_ff == S_IDLE)
      else $error("loaded result not presented");

   // The FIR drain is entered only after the full tap sweep
   a_sweep_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIRWAIT) && ($past(state_ff) == S_FIR) |-> $past(cnt_ff) == FIR_LAST)
      else $error("FIR sweep ended early");

endmodule

### tb/dc_block_then_fir_bandpass_tb.sv
// Self-checking testbench for the DC blocker and FIR bandpass block, with its own filter predictor.
`timescale 1ns / 1ps

module dc_block_then_fir_bandpass_tb
   import dcf_pkg::*;
();

   localparam int TAP_N       = FIR_ORDER_DEF + 1;
   localparam int LATENCY     = FIR_ORDER_DEF + 11;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 50;
   localparam int ROWS        = 27;

   typedef struct packed {
      logic [SAMPLE_W-1:0] dc_removed;
      logic [SAMPLE_W-1:0] band_output;
      logic [DAC_W-1:0]    dac_code;
   } band_result_type;

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [15:0]         value;
      logic                typed;
      logic [SAMPLE_W-1:0] dc;
      logic [SAMPLE_W-1:0] band;
      logic [DAC_W-1:0]    dac;
   } stim_row_type;

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata  = '0;   // [9:0] adc_sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;         // [15:0] dc_removed, [31:16] band_output,
                                            // [39:32] dac_code
   logic                 csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr   = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   // Predictor state and register copy
   logic signed [SAMPLE_W-1:0] gain_current;
   logic signed [SAMPLE_W-1:0] gain_previous;
   logic signed [SAMPLE_W-1:0] gain_feedback;
   logic [DAC_W-1:0]           dac_bias;
   logic [ADC_W-1:0]           prev_adc;
   logic signed [SAMPLE_W-1:0] tap_hist [TAP_N];

   band_result_type band_expect_q [$];
   int              mismatch_count = 0;
   bit              no_idle = 1'b0;
   bit              cfg_open = 1'b0;

   // Directed stimulus: reset response, input extremes, register extremes
   stim_row_type directed_rows [ROWS] = '{
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd0,    1'b1, 16'd0, 16'd0, 8'd127},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd0,    1'b1, 16'd0, 16'd0, 8'd127},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd0,    1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd0,    1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd512,  1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'h155,  1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'h2AA,  1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_CSR,    CSR_DC_NUM_CURRENT,  16'h8000, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_CSR,    CSR_DC_NUM_PREVIOUS, 16'h7FFF, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_CSR,    CSR_DC_FEEDBACK,     16'h8000, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_CSR,    CSR_DAC_OFFSET,      16'h00FF, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd0,    1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd0,    1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1,    1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1022, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_CSR,    CSR_DC_FEEDBACK,     16'h7FFF, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_CSR,    CSR_DAC_OFFSET,      16'h0000, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd0,    1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0},
      '{ROW_SAMPLE, CSR_DC_NUM_CURRENT,  16'd1023, 1'b0, 16'd0, 16'd0, 8'd0}
   };

   dc_block_then_fir_bandpass DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #5_000_000;
      $display("dc_block_then_fir_bandpass test failed");
      $finish;
   end

   // Clear filter history and load register defaults
   function automatic void model_reset();
      gain_current  = DC_NUM_CURRENT_RST;
      gain_previous = DC_NUM_PREVIOUS_RST;
      gain_feedback = DC_FEEDBACK_RST;
      dac_bias      = DAC_OFFSET_RST;
      prev_adc      = '0;
      for (int k = 0; k < TAP_N; k++) tap_hist[k] = '0;
   endfunction

   function automatic void model_write(input logic [CSR_IDX_W-1:0] idx,
                                       input logic [CSR_W-1:0] value);
      case (idx)
         CSR_DC_NUM_CURRENT:  gain_current  = value;
         CSR_DC_NUM_PREVIOUS: gain_previous = value;
         CSR_DC_FEEDBACK:     gain_feedback = value;
         CSR_DAC_OFFSET:      dac_bias      = value[DAC_W-1:0];
         default: ;
      endcase
   endfunction

   // Advance the blocker and FIR by one sample; all sums wrap at 32 bits
   function automatic band_result_type filter_sample(input logic [ADC_W-1:0] x);
      int              acc;
      logic signed [SAMPLE_W-1:0] y;
      band_result_type r;
      acc = int'(x) * int'(gain_current) + int'(prev_adc) * int'(gain_previous)
            + int'(tap_hist[0]) * int'(gain_feedback);
      y = acc[31:16];
      prev_adc = x;
      for (int k = TAP_N - 1; k > 0; k--) tap_hist[k] = tap_hist[k-1];
      tap_hist[0] = y;
      acc = 0;
      for (int k = 0; k < COEF_COUNT && k < TAP_N; k++) begin
         acc = acc + int'(BAND_COEF[k]) * int'(tap_hist[k]);
      end
      r.dc_removed  = y;
      r.band_output = acc[31:16];
      r.dac_code    = r.band_output[DAC_W:1] + dac_bias;
      return r;
   endfunction

   function automatic int draw_wait();
      if (no_idle) return 0;
      return $urandom_range(0, 10);
   endfunction

   function automatic logic [CSR_W-1:0] pick_gain();
      case ($urandom_range(0, 3))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return CSR_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [ADC_W-1:0] pick_sample(input logic [ADC_W-1:0] last);
      int t;
      case ($urandom_range(0, 3))
         0: t = $urandom_range(0, 1) ? 1023 : 0;
         1: begin
            // drift near the last value, like a slow input
            t = int'(last) + $urandom_range(0, 64) - 32;
            if (t < 0) t = 0;
            if (t > 1023) t = 1023;
         end
         default: t = $urandom_range(0, 1023);
      endcase
      return ADC_W'(t);
   endfunction

   // Drop the write enable after a run of register writes
   task automatic cfg_close();
      if (cfg_open) begin
         csr_wr_en <= 1'b0;
         cfg_open = 1'b0;
      end
   endtask

   task automatic cfg_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      cfg_open = 1'b1;
      @(posedge clock);
      model_write(idx, value);
   endtask

   // Hold off the sender until every result has come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (band_expect_q.size() != 0);
   endtask

   // Offer one item and return at the edge that accepts it
   task automatic send_sample(input logic [ADC_W-1:0] x);
      int gap;
      gap = draw_wait();
      cfg_close();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(16-ADC_W){1'b0}}, x};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      band_expect_q.push_back(filter_sample(x));
   endtask

   // Stimulus
   initial begin : req_side
      band_result_type  typed_r;
      logic [ADC_W-1:0] x;
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (!cfg_open) wait_idle();
            cfg_write(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            send_sample(directed_rows[i].value[ADC_W-1:0]);
            if (directed_rows[i].typed) begin
               typed_r.dc_removed  = directed_rows[i].dc;
               typed_r.band_output = directed_rows[i].band;
               typed_r.dac_code    = directed_rows[i].dac;
               band_expect_q[band_expect_q.size()-1] = typed_r;
            end
         end
      end

      // Random phases, each under its own register setting
      x = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               cfg_write(CSR_DC_NUM_CURRENT, 16'h7FFF);
               cfg_write(CSR_DC_NUM_PREVIOUS, 16'h7FFF);
               cfg_write(CSR_DC_FEEDBACK, 16'h7FFF);
               cfg_write(CSR_DAC_OFFSET, 16'h00FF);
            end
            1: begin
               cfg_write(CSR_DC_NUM_CURRENT, 16'h8000);
               cfg_write(CSR_DC_NUM_PREVIOUS, 16'h8000);
               cfg_write(CSR_DC_FEEDBACK, 16'h8000);
               cfg_write(CSR_DAC_OFFSET, 16'h0000);
            end
            2: begin
               cfg_write(CSR_DC_NUM_CURRENT, DC_NUM_CURRENT_RST);
               cfg_write(CSR_DC_NUM_PREVIOUS, DC_NUM_PREVIOUS_RST);
               cfg_write(CSR_DC_FEEDBACK, DC_FEEDBACK_RST);
               cfg_write(CSR_DAC_OFFSET, CSR_W'(DAC_OFFSET_RST));
            end
            default: begin
               cfg_write(CSR_DC_NUM_CURRENT, pick_gain());
               cfg_write(CSR_DC_NUM_PREVIOUS, pick_gain());
               cfg_write(CSR_DC_FEEDBACK, pick_gain());
               cfg_write(CSR_DAC_OFFSET, CSR_W'($urandom_range(0, 255)));
            end
         endcase
         no_idle = (phase == 5);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // pause mid-stream until the block has drained
            if (phase == 3 && n == PHASE_ITEMS / 2) wait_idle();
            x = pick_sample(x);
            send_sample(x);
         end
      end
      no_idle = 1'b0;

      // Drain and give the verdict
      wait_idle();
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0 && band_expect_q.size() == 0) begin
         $display("dc_block_then_fir_bandpass test passed");
      end else begin
         $display("dc_block_then_fir_bandpass test failed");
      end
      $finish;
   end

   // Result side: stall at random, check each accepted item against the oldest expectation
   initial begin : rsp_side
      int              stall;
      band_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         if (band_expect_q.size() == 0) begin
            $error("result item with no expectation: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = band_expect_q.pop_front();
            if (rsp_tdata[15:0] !== want.dc_removed) begin
               $error("dc_removed: expected %0d, got %0d",
                      $signed(want.dc_removed), $signed(rsp_tdata[15:0]));
               mismatch_count++;
            end
            if (rsp_tdata[31:16] !== want.band_output) begin
               $error("band_output: expected %0d, got %0d",
                      $signed(want.band_output), $signed(rsp_tdata[31:16]));
               mismatch_count++;
            end
            if (rsp_tdata[39:32] !== want.dac_code) begin
               $error("dac_code: expected %0d, got %0d", want.dac_code, rsp_tdata[39:32]);
               mismatch_count++;
            end
         end
         @(posedge clock);
      end
   end

endmodule

### files.f
hw/rtl/dcf_pkg.sv
hw/rtl/dcf_tap_cell.sv
hw/rtl/dcf_mac.sv
hw/rtl/dc_block_then_fir_bandpass.sv
tb/dc_block_then_fir_bandpass_tb.sv
